// ===== sv/ihs_pkg.sv =====
// shared types, signatures and helpers for the image header size sniffer
`timescale 1ns / 1ps

package ihs_pkg;

    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_JPEG    = 2'd1,
        FMT_PNG     = 2'd2,
        FMT_GIF     = 2'd3
    } t_format;

    typedef enum logic [1:0] {
        PH_SEARCH   = 2'd0,
        PH_CAPTURE  = 2'd1,
        PH_PNG_TAIL = 2'd2,
        PH_DONE     = 2'd3
    } t_phase;

    typedef struct packed {
        t_format     format;
        logic        size_found;
        logic [31:0] width;
        logic [31:0] height;
    } t_result;

    // signatures, left aligned, first byte in the top bits
    localparam logic [63:0] SIG_JPG  = 64'hFFD8_0000_0000_0000;
    localparam logic [63:0] SIG_JPG2 = 64'hFFD9_FFD8_0000_0000;
    localparam logic [63:0] SIG_PNG  = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [63:0] SIG_GIF  = 64'h4749_4638_3961_0000;

    localparam logic [3:0] LEN_JPG  = 4'd2;
    localparam logic [3:0] LEN_JPG2 = 4'd4;
    localparam logic [3:0] LEN_PNG  = 4'd8;
    localparam logic [3:0] LEN_GIF  = 4'd6;

    localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
    localparam logic [7:0]  MARKER_SOF0   = 8'hC0;
    localparam logic [31:0] CHUNK_IHDR    = 32'h4948_4452;

    localparam logic [3:0] POS_MAX     = 4'd15;
    localparam logic [3:0] GIF_MIN_LEN = 4'd10;

    // flag bits
    localparam int F_JPG  = 0;
    localparam int F_JPG2 = 1;
    localparam int F_PNG  = 2;
    localparam int F_GIF  = 3;

    function automatic logic [7:0] sig_byte(input logic [63:0] sig, input logic [2:0] idx);
        return sig[8*(7-idx) +: 8];
    endfunction

    function automatic t_format settled_format(input logic [3:0] flags,
                                               input logic [3:0] count);
        t_format f;
        f = FMT_UNKNOWN;
        if (flags[F_JPG] && count >= LEN_JPG) begin
            f = FMT_JPEG;
        end else if (flags[F_JPG2] && count >= LEN_JPG2) begin
            f = FMT_JPEG;
        end else if (flags[F_PNG] && count >= LEN_PNG) begin
            f = FMT_PNG;
        end else if (flags[F_GIF] && count >= LEN_GIF) begin
            f = FMT_GIF;
        end
        return f;
    endfunction

endpackage

// ===== sv/ihs_byte_if.sv =====
// byte stream channel: one file byte and its last flag
`timescale 1ns / 1ps

interface ihs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== sv/ihs_result_if.sv =====
// result channel: detected format and image size
`timescale 1ns / 1ps

interface ihs_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  format;
    logic        size_found;
    logic [31:0] width;
    logic [31:0] height;

    modport source (output valid, output format, output size_found, output width,
                    output height, input ready);
    modport sink   (input valid, input format, input size_found, input width,
                    input height, output ready);
endinterface

// ===== sv/ihs_parser.sv =====
// per-byte signature match and size field capture
`timescale 1ns / 1ps

module ihs_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last,
    output ihs_pkg::t_result o_result
);
    import ihs_pkg::*;

    logic [3:0]  r_pos,     n_pos;
    logic [3:0]  r_flags,   n_flags;
    logic [23:0] r_recent,  n_recent;
    logic [3:0]  r_count,   n_count;
    t_phase      r_phase,   n_phase;
    logic [31:0] r_width,   n_width;
    logic [31:0] r_height,  n_height;

    t_format     fmt;
    t_format     res_fmt;
    logic        found;

    always_comb begin
        n_pos    = (r_pos != POS_MAX) ? r_pos + 4'd1 : r_pos;
        n_flags  = r_flags;
        n_recent = {r_recent[15:0], i_data_byte};
        n_count  = r_count;
        n_phase  = r_phase;
        n_width  = r_width;
        n_height = r_height;

        fmt = settled_format(r_flags, r_pos);

        if (r_pos < LEN_JPG && i_data_byte != sig_byte(SIG_JPG, r_pos[2:0])) begin
            n_flags[F_JPG] = 1'b0;
        end
        if (r_pos < LEN_JPG2 && i_data_byte != sig_byte(SIG_JPG2, r_pos[2:0])) begin
            n_flags[F_JPG2] = 1'b0;
        end
        if (r_pos < LEN_PNG && i_data_byte != sig_byte(SIG_PNG, r_pos[2:0])) begin
            n_flags[F_PNG] = 1'b0;
        end
        if (r_pos < LEN_GIF && i_data_byte != sig_byte(SIG_GIF, r_pos[2:0])) begin
            n_flags[F_GIF] = 1'b0;
        end

        case (fmt)
            FMT_JPEG: begin
                if (r_phase == PH_SEARCH) begin
                    if (r_recent[7:0] == MARKER_PREFIX && i_data_byte == MARKER_SOF0) begin
                        n_phase = PH_CAPTURE;
                        n_count = 4'd0;
                    end
                end else if (r_phase == PH_CAPTURE) begin
                    // height at offsets 5..6, width at 7..8 from the ff
                    case (r_count)
                        4'd3: n_height = {16'd0, i_data_byte, 8'd0};
                        4'd4: n_height = {r_height[31:8], i_data_byte};
                        4'd5: n_width  = {16'd0, i_data_byte, 8'd0};
                        4'd6: begin
                            n_width = {r_width[31:8], i_data_byte};
                            n_phase = PH_DONE;
                        end
                        default: ;
                    endcase
                    n_count = r_count + 4'd1;
                end
            end
            FMT_PNG: begin
                if (r_phase == PH_SEARCH) begin
                    if ({r_recent, i_data_byte} == CHUNK_IHDR) begin
                        n_phase  = PH_CAPTURE;
                        n_count  = 4'd0;
                        n_width  = 32'd0;
                        n_height = 32'd0;
                    end
                end else if (r_phase == PH_CAPTURE) begin
                    if (r_count < 4'd4) begin
                        n_width = {r_width[23:0], i_data_byte};
                    end else begin
                        n_height = {r_height[23:0], i_data_byte};
                    end
                    if (r_count >= 4'd7) begin
                        n_phase = PH_PNG_TAIL;
                    end
                    n_count = r_count + 4'd1;
                end else if (r_phase == PH_PNG_TAIL) begin
                    n_phase = PH_DONE;
                end
            end
            FMT_GIF: begin
                // little-endian fields at bytes 6..9
                case (r_pos)
                    4'd6: n_width  = {24'd0, i_data_byte};
                    4'd7: n_width  = {16'd0, i_data_byte, r_width[7:0]};
                    4'd8: n_height = {24'd0, i_data_byte};
                    4'd9: n_height = {16'd0, i_data_byte, r_height[7:0]};
                    default: ;
                endcase
            end
            default: ;
        endcase

        res_fmt = settled_format(n_flags, n_pos);
        case (res_fmt)
            FMT_JPEG, FMT_PNG: found = (n_phase == PH_DONE);
            FMT_GIF:           found = (n_pos >= GIF_MIN_LEN);
            default:           found = 1'b0;
        endcase

        o_result.format     = res_fmt;
        o_result.size_found = found;
        o_result.width      = found ? n_width  : 32'd0;
        o_result.height     = found ? n_height : 32'd0;
    end

    // the last byte of a file returns the parser to its reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_pos    <= 4'd0;
            r_flags  <= 4'hF;
            r_recent <= 24'd0;
            r_count  <= 4'd0;
            r_phase  <= PH_SEARCH;
            r_width  <= 32'd0;
            r_height <= 32'd0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_recent <= n_recent;
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

endmodule

// ===== sv/image_header_size_sniffer.sv =====
// top level: image format and size detection over a byte stream
//
//   channel    dir   handshake      payload
//   i_byte     in    valid/ready    data_byte[7:0], last
//   o_result   out   valid/ready    format[1:0], size_found, width[31:0], height[31:0]
//
// one byte per cycle while i_byte is ready; the state update for a byte is a single combinational step
// a result is registered from the transaction carrying last and is valid in the cycle after it
// i_byte is ready while the result register is empty or being drained
// synchronous active-low reset clears the parser and the valid flag of the result register
`timescale 1ns / 1ps

module image_header_size_sniffer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ihs_byte_if.sink            i_byte,
    ihs_result_if.source        o_result
);
    import ihs_pkg::*;

    logic    in_accept;
    t_result step_result;
    logic    r_out_valid;
    t_result r_out;

    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign in_accept    = i_byte.valid && i_byte.ready;

    ihs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_byte.data_byte),
        .i_last      (i_byte.last),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_byte.last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_byte.last) begin
            r_out <= step_result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.format     = r_out.format;
    assign o_result.size_found = r_out.size_found;
    assign o_result.width      = r_out.width;
    assign o_result.height     = r_out.height;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_byte.ready)
        else $error("input stalled with empty result register");

    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_accept && i_byte.last))
        else $error("result appeared without a last transaction");

    a_found_has_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.size_found) |-> (r_out.format != FMT_UNKNOWN))
        else $error("size found for unknown format");

    a_missing_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.size_found) |-> (r_out.width == 32'd0 && r_out.height == 32'd0))
        else $error("nonzero size reported without size_found");

endmodule
